@@ rtl/vpc_pkg.sv @@
// Shared types, reset values and constants of the valve position controller.
`default_nettype none

package vpc_pkg;

  // Default tracked position width in encoder steps
  localparam int unsigned POSITION_WIDTH_DEF = 32;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 32;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_STEPS_PER_UNIT = 3'd0,
    REG_STALL_LIMIT    = 3'd1,
    REG_IDLE_LIMIT     = 3'd2,
    REG_HOME_THRESHOLD = 3'd3,
    REG_DRIVE_DUTY     = 3'd4,
    REG_TIMER_PERIOD   = 3'd5
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [7:0]         RST_STEPS_PER_UNIT = 8'd42;
  localparam logic [7:0]         RST_STALL_LIMIT    = 8'd40;
  localparam logic [7:0]         RST_IDLE_LIMIT     = 8'd180;
  localparam logic signed [31:0] RST_HOME_THRESHOLD = -32'sd5000;
  localparam logic [7:0]         RST_DRIVE_DUTY     = 8'd85;
  localparam logic [23:0]        RST_TIMER_PERIOD   = 24'd1000;

  // PWM compare arithmetic: duty in percent, zero duty maps to a factor of 101
  localparam logic [7:0]  DUTY_FULL   = 8'd100;
  localparam logic [6:0]  K_FULL      = 7'd100;
  localparam logic [6:0]  K_ZERO_DUTY = 7'd101;
  // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for y below 2**29
  localparam logic [29:0] RECIP_25    = 30'd687194768;
  localparam int unsigned RECIP_SHIFT = 34;

  localparam logic [7:0] COUNT_SAT = 8'hFF;

  typedef struct packed {
    logic [7:0]         steps_per_unit;
    logic [7:0]         stall_limit;
    logic [7:0]         idle_limit;
    logic signed [31:0] home_threshold;
    logic [7:0]         drive_duty;
    logic [23:0]        timer_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         motor_state;
    logic               direction;
    logic signed [31:0] position;
    logic signed [31:0] target_steps;
    logic [31:0]        edge_count;
    logic [24:0]        pwm_compare;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/vpc_pwm.sv @@
// Two-stage PWM compare value: period times duty factor, then divide by 100.
`default_nettype none

module vpc_pwm (
  input  wire logic        clk,
  input  wire logic [7:0]  drive_duty,
  input  wire logic [23:0] timer_period,
  output logic [24:0]      pwm_compare
);
  import vpc_pkg::*;

  logic [7:0]  duty_clamped;
  logic [6:0]  k_factor;
  logic [30:0] prod;
  logic [28:0] prod_div4;
  logic [58:0] recip_prod;

  // Clamp duty and form the off-time factor
  always_comb begin
    duty_clamped = (drive_duty > DUTY_FULL) ? DUTY_FULL : drive_duty;
    k_factor     = 7'(DUTY_FULL - duty_clamped);
    if (k_factor == K_FULL) begin
      k_factor = K_ZERO_DUTY;
    end
  end

  // Divide by 100 as a shift by two and a reciprocal multiply by 25
  assign prod_div4  = prod[30:2];
  assign recip_prod = {30'd0, prod_div4} * {29'd0, RECIP_25};

  // Register each product
  always_ff @(posedge clk) begin
    prod        <= 31'(timer_period) * 31'(k_factor);
    pwm_compare <= recip_prod[58:RECIP_SHIFT];
  end

endmodule

`default_nettype wire

@@ rtl/vpc_update.sv @@
// Controller state and the combinational update for one set or tick beat.
`default_nettype none

module vpc_update #(
  parameter int unsigned POSITION_WIDTH = vpc_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire logic               mode,
  input  wire logic signed [15:0] target_units,
  input  wire logic               encoder_level,
  input  wire vpc_pkg::cfg_t      cfg,
  input  wire logic [24:0]        pwm_compare,
  output vpc_pkg::result_t        result
);
  import vpc_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam int unsigned XW = (PW > 25) ? PW : 25;
  localparam int unsigned OW = (PW > 32) ? PW : 32;

  typedef enum logic [1:0] {
    ST_OFF   = 2'd0,
    ST_IDLE  = 2'd1,
    ST_BRAKE = 2'd2,
    ST_DRIVE = 2'd3
  } state_t;

  state_t        ctrl_state, ctrl_state_next;
  logic          drive_dir, drive_dir_next;
  logic [PW-1:0] pos_steps, pos_steps_next;
  logic [PW-1:0] target_reg, target_reg_next;
  logic          last_level, last_level_next;
  logic [7:0]    stall_count, stall_count_next;
  logic [7:0]    idle_count, idle_count_next;
  logic [31:0]   edges_total, edges_total_next;

  logic signed [24:0] set_prod;
  logic signed [XW-1:0] set_prod_x;
  logic [PW-1:0]      set_target;
  logic               below_home;
  logic signed [OW-1:0] pos_x;
  logic signed [OW-1:0] tgt_x;

  // Scale the requested units into encoder steps, wrapping at the position width
  assign set_prod   = target_units * $signed({1'b0, cfg.steps_per_unit});
  assign set_prod_x = XW'(set_prod);
  assign set_target = set_prod_x[PW-1:0];

  // Rezero test on the current target
  assign below_home = $signed(OW'($signed(target_reg))) < $signed(OW'(cfg.home_threshold));

  // Next state for one beat
  always_comb begin
    ctrl_state_next  = ctrl_state;
    drive_dir_next   = drive_dir;
    pos_steps_next   = pos_steps;
    target_reg_next  = target_reg;
    last_level_next  = last_level;
    stall_count_next = stall_count;
    idle_count_next  = idle_count;
    edges_total_next = edges_total;
    if (!mode) begin
      target_reg_next = set_target;
      if (set_target != pos_steps) begin
        drive_dir_next   = $signed(set_target) > $signed(pos_steps);
        ctrl_state_next  = ST_DRIVE;
        stall_count_next = 8'd0;
      end
    end else if (ctrl_state != ST_OFF) begin
      if (encoder_level != last_level) begin
        last_level_next  = encoder_level;
        edges_total_next = edges_total + 32'd1;
        stall_count_next = 8'd0;
        pos_steps_next   = drive_dir ? (pos_steps + PW'(1)) : (pos_steps - PW'(1));
      end else if (stall_count != COUNT_SAT) begin
        stall_count_next = stall_count + 8'd1;
      end
      if (stall_count_next > cfg.stall_limit) begin
        ctrl_state_next = ST_IDLE;
      end
      if (pos_steps_next == target_reg) begin
        ctrl_state_next = ST_BRAKE;
      end
      if (ctrl_state_next == ST_IDLE || ctrl_state_next == ST_BRAKE) begin
        if (idle_count != COUNT_SAT) begin
          idle_count_next = idle_count + 8'd1;
        end
      end else begin
        idle_count_next = 8'd0;
      end
      if (idle_count_next > cfg.idle_limit) begin
        ctrl_state_next = ST_OFF;
        if (below_home) begin
          pos_steps_next  = '0;
          target_reg_next = '0;
        end
      end
    end
  end

  // Result reflects the state after this beat
  assign pos_x = OW'($signed(pos_steps_next));
  assign tgt_x = OW'($signed(target_reg_next));

  always_comb begin
    result.motor_state  = ctrl_state_next;
    result.direction    = drive_dir_next;
    result.position     = pos_x[31:0];
    result.target_steps = tgt_x[31:0];
    result.edge_count   = edges_total_next;
    result.pwm_compare  = pwm_compare;
  end

  // Hold state, update on each advancing beat
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_state  <= ST_OFF;
      drive_dir   <= 1'b0;
      pos_steps   <= '0;
      target_reg  <= '0;
      last_level  <= 1'b0;
      stall_count <= 8'd0;
      idle_count  <= 8'd0;
      edges_total <= 32'd0;
    end else if (advance) begin
      ctrl_state  <= ctrl_state_next;
      drive_dir   <= drive_dir_next;
      pos_steps   <= pos_steps_next;
      target_reg  <= target_reg_next;
      last_level  <= last_level_next;
      stall_count <= stall_count_next;
      idle_count  <= idle_count_next;
      edges_total <= edges_total_next;
    end
  end

  // A tick while off leaves the controller off and the position alone
  a_off_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && mode && ctrl_state == ST_OFF) |=>
      (ctrl_state == ST_OFF && $stable(pos_steps)))
    else $error("tick while off changed state or position");

  // An encoder edge while running clears the stall count
  a_edge_clears_stall: assert property (@(posedge clk) disable iff (rst)
    (advance && mode && ctrl_state != ST_OFF && encoder_level != last_level) |=>
      (stall_count == 8'd0))
    else $error("encoder edge did not clear stall count");

endmodule

`default_nettype wire

@@ rtl/vpc_out_buf.sv @@
// Two-entry result buffer: output register plus a skid entry.
`default_nettype none

module vpc_out_buf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire vpc_pkg::result_t push_data,
  output logic                  room,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output vpc_pkg::result_t      out_data
);
  import vpc_pkg::*;

  result_t skid_data;
  logic    skid_valid;
  logic    pop;

  assign pop  = out_valid && !out_stall;
  assign room = !skid_valid;

  // Control: refill the output from the skid entry first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || pop) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (!out_valid || pop) begin
      if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  // The skid entry is only ever filled behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry valid with empty output register");

  // A beat pushed against a stalled output lands in the skid entry
  a_push_to_skid: assert property (@(posedge clk) disable iff (rst)
    (push && out_valid && !pop) |=> skid_valid)
    else $error("beat pushed against stalled output was dropped");

endmodule

`default_nettype wire

@@ rtl/valve_position_controller_core.sv @@
// Valve position controller: bang-bang motor positioner with encoder step counting.
//
// Input channel (in_valid / in_stall): mode 0 sets a new target from target_units,
// mode 1 is a periodic sample tick carrying encoder_level. Each input beat yields
// exactly one result beat on the output channel (out_valid / out_stall) with
// motor_state, direction, position, target_steps, edge_count and pwm_compare.
// An accepted input beat sits in the input register until the result buffer has room,
// then its result is pushed into the output register or, behind a stalled output, the
// skid entry. Throughput is one beat per cycle while in_stall is low; the state
// update loop is combinational compare and add/subtract logic.
// A two-entry result buffer parts the channels: input is still taken while one
// result waits under out_stall, and in_stall rises once both buffer entries and the
// input register are full.
// Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data) is always ready; the
// PWM compare pipeline must follow a write through its registers, so in_stall stays high
// during the write cycle and the cycle after it.
// Reset (rst, synchronous) restores register defaults, clears the controller to
// off at position zero, empties the buffer and holds in_stall high in the cycle after it.
`default_nettype none

module valve_position_controller_core #(
  parameter int unsigned POSITION_WIDTH = vpc_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Input channel
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           mode,
  input  wire logic signed [15:0]             target_units,
  input  wire logic                           encoder_level,
  // Output channel
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [1:0]                          motor_state,
  output logic                                direction,
  output logic signed [31:0]                  position,
  output logic signed [31:0]                  target_steps,
  output logic [31:0]                         edge_count,
  output logic [24:0]                         pwm_compare,
  // Configuration write channel
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vpc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [vpc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import vpc_pkg::*;

  cfg_t        cfg;
  logic        settle;
  logic        cfg_fire;
  logic        stage_valid;
  logic        stage_mode;
  logic signed [15:0] stage_units;
  logic        stage_level;
  logic        load;
  logic        advance;
  logic        room;
  logic [24:0] pwm_value;
  result_t     step_result;
  result_t     out_data;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steps_per_unit <= RST_STEPS_PER_UNIT;
      cfg.stall_limit    <= RST_STALL_LIMIT;
      cfg.idle_limit     <= RST_IDLE_LIMIT;
      cfg.home_threshold <= RST_HOME_THRESHOLD;
      cfg.drive_duty     <= RST_DRIVE_DUTY;
      cfg.timer_period   <= RST_TIMER_PERIOD;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_STEPS_PER_UNIT: cfg.steps_per_unit <= cfg_data[7:0];
        REG_STALL_LIMIT:    cfg.stall_limit    <= cfg_data[7:0];
        REG_IDLE_LIMIT:     cfg.idle_limit     <= cfg_data[7:0];
        REG_HOME_THRESHOLD: cfg.home_threshold <= $signed(cfg_data[31:0]);
        REG_DRIVE_DUTY:     cfg.drive_duty     <= cfg_data[7:0];
        REG_TIMER_PERIOD:   cfg.timer_period   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Hold input in the cycle after reset or a write while the PWM pipeline settles
  always_ff @(posedge clk) begin
    if (rst) begin
      settle <= 1'b1;
    end else begin
      settle <= cfg_fire;
    end
  end

  // Input register
  assign advance  = stage_valid && room;
  assign in_stall = rst || settle || cfg_valid || (stage_valid && !room);
  assign load     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (load) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stage_mode  <= mode;
      stage_units <= target_units;
      stage_level <= encoder_level;
    end
  end

  vpc_pwm u_pwm (
    .clk          (clk),
    .drive_duty   (cfg.drive_duty),
    .timer_period (cfg.timer_period),
    .pwm_compare  (pwm_value)
  );

  vpc_update #(
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_update (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .mode          (stage_mode),
    .target_units  (stage_units),
    .encoder_level (stage_level),
    .cfg           (cfg),
    .pwm_compare   (pwm_value),
    .result        (step_result)
  );

  vpc_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .push_data (step_result),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Unpack the result beat
  assign motor_state  = out_data.motor_state;
  assign direction    = out_data.direction;
  assign position     = out_data.position;
  assign target_steps = out_data.target_steps;
  assign edge_count   = out_data.edge_count;
  assign pwm_compare  = out_data.pwm_compare;

endmodule

`default_nettype wire
